// File: design/kscg_pkg.sv
// Shared types and constants for the k-subset combination generator.
package kscg_pkg;

  localparam int IDX_FIELDS    = 8;
  localparam int IDX_W         = 5;
  localparam int ORD_W         = 24;
  localparam int SET_SIZE_W    = 6;
  localparam int SUBSET_SIZE_W = 4;
  localparam int CFG_INDEX_W   = 2;
  localparam int DATA_W        = IDX_FIELDS * IDX_W + ORD_W;
  localparam int S_DATA_W      = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_SET_SIZE    = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_SUBSET_SIZE = CFG_INDEX_W'(1);

  localparam logic [SET_SIZE_W-1:0]    SET_SIZE_RESET    = SET_SIZE_W'(5);
  localparam logic [SUBSET_SIZE_W-1:0] SUBSET_SIZE_RESET = SUBSET_SIZE_W'(3);

  typedef struct packed {
    logic [ORD_W-1:0]                 ordinal;
    logic                             none;
    logic                             is_last;
    logic [IDX_FIELDS-1:0][IDX_W-1:0] idx;
  } result_t;

endpackage

// File: design/kscg_succ.sv
// Successor logic: first or next combination, ordinal and last flag.
module kscg_succ import kscg_pkg::*; #(
  parameter int MAX_SUBSET = 8,
  parameter int MAX_SET    = 32,
  localparam int CW = $clog2(MAX_SET + MAX_SUBSET + 1),
  localparam int PW = $clog2(MAX_SUBSET)
) (
  input  logic [SET_SIZE_W-1:0]             set_size,
  input  logic [SUBSET_SIZE_W-1:0]          subset_size,
  input  logic [MAX_SUBSET-1:0][CW-1:0]     cur,
  input  logic                              started,
  input  logic [ORD_W-1:0]                  pos_count,
  input  logic                              restart,
  output logic [MAX_SUBSET-1:0][CW-1:0]     cur_next,
  output logic                              started_next,
  output logic [ORD_W-1:0]                  pos_count_next,
  output result_t                           res
);

  logic [CW-1:0]                        n;
  logic [SUBSET_SIZE_W-1:0]             k_raw;
  logic [CW-1:0]                        k;
  logic                                 none;
  logic                                 found;
  logic [PW-1:0]                        pos;
  logic                                 first;
  logic                                 last;
  logic [CW-1:0]                        base;
  logic [MAX_SUBSET-1:0][CW-1:0]        ceil_val;
  logic [MAX_SUBSET-1:0][CW-1:0]        nxt;
  logic [IDX_FIELDS-1:0][IDX_W-1:0]     idx_out;

  always_comb begin
    n = ({1'b0, set_size} > 7'(MAX_SET)) ? CW'(MAX_SET) : CW'(set_size);
    k_raw = (subset_size == '0) ? SUBSET_SIZE_W'(1) : subset_size;
    k = (k_raw > SUBSET_SIZE_W'(MAX_SUBSET)) ? CW'(MAX_SUBSET) : CW'(k_raw);
    none = (k > n);

    found = 1'b0;
    pos   = '0;
    for (int p = 0; p < MAX_SUBSET; p++) begin
      ceil_val[p] = n - k + CW'(p);
      if ((CW'(p) < k) && (cur[p] < ceil_val[p])) begin
        found = 1'b1;
        pos   = PW'(p);
      end
    end

    first = restart || !started || !found;
    base  = cur[pos] + CW'(1);

    for (int q = 0; q < MAX_SUBSET; q++) begin
      if (CW'(q) >= k) begin
        nxt[q] = '0;
      end else if (first) begin
        nxt[q] = CW'(q);
      end else if (PW'(q) < pos) begin
        nxt[q] = cur[q];
      end else begin
        nxt[q] = base + CW'(q) - CW'(pos);
      end
    end

    last = 1'b1;
    for (int q = 0; q < MAX_SUBSET; q++) begin
      if ((CW'(q) < k) && (nxt[q] != ceil_val[q])) begin
        last = 1'b0;
      end
    end

    if (none) begin
      cur_next       = cur;
      pos_count_next = pos_count;
    end else begin
      cur_next       = nxt;
      pos_count_next = first ? '0 : pos_count + ORD_W'(1);
    end
    started_next = !none;

    res.idx     = idx_out;
    res.is_last = none || last;
    res.none    = none;
    res.ordinal = none ? '0 : pos_count_next;
  end

  for (genvar f = 0; f < IDX_FIELDS; f++) begin : g_idx
    if (f < MAX_SUBSET) begin : g_used
      assign idx_out[f] = (!none && (CW'(f) < k)) ? IDX_W'(nxt[f]) : '0;
    end else begin : g_unused
      assign idx_out[f] = '0;
    end
  end

endmodule

// File: design/kscg_out.sv
// Output register stage holding one result item.
module kscg_out import kscg_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  result_t in_res,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      out_res <= in_res;
    end
  end

endmodule

// File: design/k_subset_combination_generator.sv
// Top level of the k-subset combination generator.
// Each request item returns one k-combination of 0..n-1 in lexicographic
// order: restart (s_tdata bit 0) or the first request after reset or after
// a register write gives 0..k-1, otherwise the successor follows, wrapping
// to the first after the last. One item is taken every cycle unless the
// output stalls, and its result appears in the next cycle from the output
// register; the rate is set by the combinational successor logic, a compare
// and rightmost pick over MAX_SUBSET positions feeding the state registers.
// If k exceeds n the result has the none flag (tuser) set and tlast high.
module k_subset_combination_generator import kscg_pkg::*; #(
  parameter int MAX_SUBSET = 8,
  parameter int MAX_SET    = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [S_DATA_W-1:0]      s_tdata,   // [0] restart, rest zero
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [DATA_W-1:0]        m_tdata,   // idx_0..idx_7 (5b each), ordinal
  output logic                     m_tlast,
  output logic                     m_tuser,   // none
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [SET_SIZE_W-1:0]    cfg_data
);

  localparam int CW = $clog2(MAX_SET + MAX_SUBSET + 1);

  logic [SET_SIZE_W-1:0]         set_size;
  logic [SUBSET_SIZE_W-1:0]      subset_size;
  logic [MAX_SUBSET-1:0][CW-1:0] cur;
  logic [MAX_SUBSET-1:0][CW-1:0] cur_next;
  logic                          started;
  logic                          started_next;
  logic [ORD_W-1:0]              pos_count;
  logic [ORD_W-1:0]              pos_count_next;
  logic                          s_acc;
  result_t                       res_c;
  result_t                       res_q;

  assign s_acc     = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  kscg_succ #(
    .MAX_SUBSET (MAX_SUBSET),
    .MAX_SET    (MAX_SET)
  ) u_succ (
    .set_size       (set_size),
    .subset_size    (subset_size),
    .cur            (cur),
    .started        (started),
    .pos_count      (pos_count),
    .restart        (s_tdata[0]),
    .cur_next       (cur_next),
    .started_next   (started_next),
    .pos_count_next (pos_count_next),
    .res            (res_c)
  );

  kscg_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_res    (res_c),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res_q)
  );

  assign m_tdata = {res_q.ordinal, res_q.idx};
  assign m_tlast = res_q.is_last;
  assign m_tuser = res_q.none;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_size    <= SET_SIZE_RESET;
      subset_size <= SUBSET_SIZE_RESET;
      cur         <= '0;
      started     <= 1'b0;
      pos_count   <= '0;
    end else begin
      if (s_acc) begin
        cur       <= cur_next;
        started   <= started_next;
        pos_count <= pos_count_next;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_SET_SIZE: begin
            set_size <= cfg_data;
            started  <= 1'b0;
          end
          REG_SUBSET_SIZE: begin
            subset_size <= cfg_data[SUBSET_SIZE_W-1:0];
            started     <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

`ifndef SYNTH
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while result stalled");

  a_none_clears: assert property (@(posedge clk) disable iff (rst)
    (s_acc && res_c.none && !cfg_valid) |=> !started)
    else $error("started kept after empty result");

  a_valid_sets: assert property (@(posedge clk) disable iff (rst)
    (s_acc && !res_c.none && !cfg_valid) |=> started)
    else $error("started not set after combination");

  a_none_shape: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == '0)))
    else $error("empty result carries data");

  a_restart_zero: assert property (@(posedge clk) disable iff (rst)
    (s_acc && s_tdata[0] && !res_c.none) |=>
      (m_tvalid && (m_tdata[DATA_W-1 -: ORD_W] == '0)))
    else $error("restart ordinal not zero");
`endif

endmodule
